// ----- rtl/core/ptd_pkg.sv -----
// Shared constants, register codes and payload types of the presence threshold debouncer.
package ptd_pkg;

	localparam int AdcBits = 12;
	localparam int RawBits = 16;
	localparam int MvBits = 12;
	localparam int RunBits = 4;
	localparam int TimeBits = 32;
	localparam int CoolBits = 16;
	localparam int CfgDataBits = 16;
	localparam int ProdBits = AdcBits + MvBits;

	localparam logic [MvBits-1:0] VrefMv = MvBits'(3000);
	localparam logic [RunBits-1:0] RunMax = '1;

	localparam logic [MvBits-1:0] ThresholdReset = MvBits'(2000);
	localparam logic [RunBits-1:0] ConfirmReset = RunBits'(3);
	localparam logic PausedReset = 1'b0;
	localparam logic [CoolBits-1:0] CooldownReset = CoolBits'(10000);

	typedef enum logic [1:0] {
		RegThreshold = 2'd0,
		RegConfirm   = 2'd1,
		RegPaused    = 2'd2,
		RegCooldown  = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OpSample    = 1'b0,
		OpIdleEntry = 1'b1
	} op_t;

	typedef struct packed {
		logic [MvBits-1:0]   threshold_mv;
		logic [RunBits-1:0]  confirm_count;
		logic                autostart_paused;
		logic [CoolBits-1:0] cooldown_ms;
	} cfg_t;

	typedef struct packed {
		logic                op;
		logic                read_ok;
		logic [RawBits-1:0]  raw_word;
		logic                machine_idle;
		logic [TimeBits-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic              sample_valid;
		logic [MvBits-1:0] sample_mv;
		logic              present;
		logic              report;
		logic              start_request;
		logic [MvBits-1:0] last_good_mv;
	} res_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} stage_t;

endpackage

// ----- rtl/core/ptd_if.sv -----
// Request and result channel interfaces of the presence threshold debouncer.
interface ptd_req_if;
	import ptd_pkg::*;

	logic                valid;
	logic                ready;
	logic                op;
	logic                read_ok;
	logic [RawBits-1:0]  raw_word;
	logic                machine_idle;
	logic [TimeBits-1:0] now_ms;

	modport source (output valid, op, read_ok, raw_word, machine_idle, now_ms, input ready);
	modport sink (input valid, op, read_ok, raw_word, machine_idle, now_ms, output ready);
endinterface

interface ptd_res_if;
	import ptd_pkg::*;

	logic              valid;
	logic              ready;
	logic              sample_valid;
	logic [MvBits-1:0] sample_mv;
	logic              present;
	logic              report;
	logic              start_request;
	logic [MvBits-1:0] last_good_mv;

	modport source (output valid, sample_valid, sample_mv, present, report, start_request,
		last_good_mv, input ready);
	modport sink (input valid, sample_valid, sample_mv, present, report, start_request,
		last_good_mv, output ready);
endinterface

// ----- rtl/core/presence_threshold_debouncer_core.sv -----
// Top level of the presence threshold debouncer.
// Each request is either a converter sample or an idle-entry event and yields exactly one
// result. The block accepts one request every clock cycle unless the result side stalls.
// A request passes through the input register and then the result register, which drives
// the result channel. The debounce and cooldown state is updated as the result is registered,
// so consecutive requests see each other's effects with no gap. When the result side stalls,
// requests are held back through the same two registers. Configuration writes take effect
// on the next cycle and are expected only while no request is in flight.
module presence_threshold_debouncer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	ptd_req_if.sink                        item,
	ptd_res_if.source                      result,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [ptd_pkg::CfgDataBits-1:0] cfg_wdata
);
	import ptd_pkg::*;

	cfg_t   cfg;
	stage_t stage;
	logic   advance;

	ptd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ptd_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (item),
		.advance (advance),
		.stage   (stage)
	);

	ptd_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.stage   (stage),
		.advance (advance),
		.res     (result)
	);

	// An auto-start is only ever requested together with a report of presence.
	a_start_needs_report: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.start_request |-> result.report && result.present)
		else $error("start request without a presence report");

	// A report is only made for a valid reading.
	a_report_needs_sample: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.report |-> result.sample_valid)
		else $error("report without a valid sample");

	// A valid reading is always the latest good reading and is never zero.
	a_sample_tracks_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.sample_valid |->
			result.last_good_mv == result.sample_mv && result.sample_mv != '0)
		else $error("valid sample not reflected in last good reading");

	// The input register never drops a request while the result side stalls.
	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		stage.valid && !advance |=> stage.valid && $stable(stage.item))
		else $error("pending request lost during stall");
endmodule

// ----- rtl/core/ptd_cfg_regs.sv -----
// Configuration register file written through the plain write port.
module ptd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [ptd_pkg::CfgDataBits-1:0] cfg_wdata,
	output ptd_pkg::cfg_t                 cfg
);
	import ptd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_mv <= ThresholdReset;
			cfg_q.confirm_count <= ConfirmReset;
			cfg_q.autostart_paused <= PausedReset;
			cfg_q.cooldown_ms <= CooldownReset;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				RegThreshold: cfg_q.threshold_mv <= cfg_wdata[MvBits-1:0];
				RegConfirm:   cfg_q.confirm_count <= cfg_wdata[RunBits-1:0];
				RegPaused:    cfg_q.autostart_paused <= cfg_wdata[0];
				RegCooldown:  cfg_q.cooldown_ms <= cfg_wdata[CoolBits-1:0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ----- rtl/core/ptd_in_stage.sv -----
// Input register that takes one request per cycle while the result side can move.
module ptd_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	ptd_req_if.sink         req,
	input  logic            advance,
	output ptd_pkg::stage_t stage
);
	import ptd_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	assign req.ready = !valid_s1 || advance;
	assign take = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{op: req.op, read_ok: req.read_ok, raw_word: req.raw_word,
				machine_idle: req.machine_idle, now_ms: req.now_ms};
		end
	end

	assign stage = '{valid: valid_s1, item: item_s1};
endmodule

// ----- rtl/core/ptd_eval.sv -----
// Scaling, threshold, debounce and cooldown logic with the state and result registers.
module ptd_eval (
	input  logic            clk,
	input  logic            arst_n,
	input  ptd_pkg::cfg_t   cfg,
	input  ptd_pkg::stage_t stage,
	output logic            advance,
	ptd_res_if.source       res
);
	import ptd_pkg::*;

	logic                present_q;
	logic                first_q;
	logic                cand_q;
	logic [RunBits-1:0]  run_q;
	logic [MvBits-1:0]   last_mv_q;
	logic [TimeBits-1:0] deadline_q;
	logic                res_valid_q;
	res_t                result_q;

	logic                present_d;
	logic                first_d;
	logic                cand_d;
	logic [RunBits-1:0]  run_d;
	logic [MvBits-1:0]   last_mv_d;
	logic [TimeBits-1:0] deadline_d;
	res_t                result_d;

	logic [AdcBits-1:0]  count;
	logic [ProdBits-1:0] product;
	logic [MvBits-1:0]   mv;
	logic [TimeBits:0]   sum;
	logic                detected;
	logic                out_free;

	assign out_free = !res_valid_q || res.ready;
	assign advance = stage.valid && out_free;

	always_comb begin
		count = stage.item.raw_word[RawBits-1 -: AdcBits];
		product = ProdBits'(count) * ProdBits'(VrefMv);
		mv = MvBits'(product >> AdcBits);
		sum = {1'b0, stage.item.now_ms} + (TimeBits+1)'(cfg.cooldown_ms);
		detected = mv < cfg.threshold_mv;

		present_d = present_q;
		first_d = first_q;
		cand_d = cand_q;
		run_d = run_q;
		last_mv_d = last_mv_q;
		deadline_d = deadline_q;
		result_d = '0;

		if (stage.item.op == OpIdleEntry) begin
			deadline_d = sum[TimeBits] ? '1 : sum[TimeBits-1:0];
		end else if (stage.item.read_ok) begin
			result_d.sample_mv = mv;
			if (mv != '0) begin
				result_d.sample_valid = 1'b1;
				last_mv_d = mv;
				if (first_q) begin
					present_d = detected;
					first_d = 1'b0;
					result_d.report = 1'b1;
					run_d = '0;
				end else if (detected != present_q) begin
					if (detected == cand_q) begin
						if (run_q != RunMax) begin
							run_d = run_q + 1'b1;
						end
					end else begin
						cand_d = detected;
						run_d = RunBits'(1);
					end
					if (run_d >= cfg.confirm_count) begin
						present_d = detected;
						result_d.report = 1'b1;
						run_d = '0;
					end
				end else begin
					run_d = '0;
				end
				result_d.start_request = result_d.report && present_d &&
					!cfg.autostart_paused && stage.item.machine_idle &&
					(stage.item.now_ms >= deadline_q);
			end
		end

		result_d.present = present_d;
		result_d.last_good_mv = last_mv_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			first_q <= 1'b1;
			cand_q <= 1'b0;
			run_q <= '0;
			last_mv_q <= '0;
			deadline_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				res_valid_q <= stage.valid;
			end
			if (advance) begin
				present_q <= present_d;
				first_q <= first_d;
				cand_q <= cand_d;
				run_q <= run_d;
				last_mv_q <= last_mv_d;
				deadline_q <= deadline_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign res.valid = res_valid_q;
	assign res.sample_valid = result_q.sample_valid;
	assign res.sample_mv = result_q.sample_mv;
	assign res.present = result_q.present;
	assign res.report = result_q.report;
	assign res.start_request = result_q.start_request;
	assign res.last_good_mv = result_q.last_good_mv;
endmodule
